@@ design/fird_pkg.sv @@
// ----------------------------------------------------------------------------
// fird_pkg: shared types and constants for the FIR decimator
// Defaults, register map, command codes, sequencer states, MAC control.
// ----------------------------------------------------------------------------
package fird_pkg;

  localparam int TAPS_DEFAULT     = 64;
  localparam int MAX_DEC_DEFAULT  = 16;

  // register map (index = byte address / 4)
  localparam int REG_DECIMATION    = 0;
  localparam int REG_FILTER_LENGTH = 1;

  localparam logic [4:0] DECIMATION_RESET    = 5'd2;
  localparam logic [6:0] FILTER_LENGTH_RESET = 7'd64;

  // item kinds on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } fird_state_t;

  // sequencer to MAC datapath
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic issue;  // a tap read was issued this cycle
    logic last;   // it is the final tap
    logic zero;   // delay entry not yet filled, treat sample as zero
  } fird_mac_ctl_t;

endpackage

@@ design/fird_ram.sv @@
// ----------------------------------------------------------------------------
// fird_ram: simple dual-port synchronous memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fird_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/fird_mac.sv @@
// ----------------------------------------------------------------------------
// fird_mac: multiply-accumulate, gain, round and saturate
// Product stage, accumulator, scale by decimation factor, round half up,
// clip to 16 bits. Result is held until taken.
// ----------------------------------------------------------------------------
module fird_mac #(
  parameter int TAPS          = fird_pkg::TAPS_DEFAULT,
  parameter int MAX_DECIMATION = fird_pkg::MAX_DEC_DEFAULT,
  localparam int DEC_W        = $clog2(MAX_DECIMATION + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  fird_pkg::fird_mac_ctl_t ctl,
  input  logic signed [15:0]      sample,   // delay RAM data, the cycle after issue
  input  logic signed [15:0]      coef,     // coefficient RAM data
  input  logic [DEC_W-1:0]        dec,
  output logic                    res_valid,
  input  logic                    res_take,
  output logic signed [15:0]      res,
  output logic                    res_sat
);

  localparam int ACC_W = 32 + $clog2(TAPS);
  localparam int SC_W  = ACC_W + DEC_W + 1;

  logic                    v1, last1, zero1;
  logic                    v2, last2;
  logic                    v3;
  logic                    v4;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [SC_W-1:0]  scaled;
  logic signed [SC_W-1:0]  rounded;
  logic signed [SC_W-1:0]  shifted;

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2 & last2;
      v4 <= v3;
      if (v4) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    last1 <= ctl.last;
    zero1 <= ctl.zero;
    last2 <= last1;
    prod  <= zero1 ? 32'sd0 : sample * coef;
    if (ctl.clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (v3) begin
      scaled <= SC_W'(acc) * $signed({1'b0, dec});
    end
    if (v4) begin
      if (shifted > SC_W'(32767)) begin
        res     <= 16'sh7fff;
        res_sat <= 1'b1;
      end else if (shifted < -SC_W'(32768)) begin
        res     <= -16'sh8000;
        res_sat <= 1'b1;
      end else begin
        res     <= shifted[15:0];
        res_sat <= 1'b0;
      end
    end
  end

  // Q.15 to integer, half up
  assign rounded = scaled + SC_W'(16384);
  assign shifted = rounded >>> 15;

endmodule

@@ design/fir_decimator.sv @@
// ----------------------------------------------------------------------------
// fir_decimator: streaming FIR decimating low-pass filter
// Samples fill a circular delay RAM; every Nth sample a sequencer walks the
// taps through the delay and coefficient RAMs into a single MAC.
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields (low bit first)
//  ---------+-----+-----------------------------------------------------------
//  s_t*     | in  | tdata: sample_in[15:0] coef_index[21:16] coef_value[37:22]
//           |     | tuser: cmd (0 sample, 1 coefficient write)
//  m_t*     | out | tdata: sample_out[15:0]; tuser: saturated
//  APB      | cfg | 0x0 decimation_factor[4:0], 0x4 filter_length[6:0]
//
// Coefficient writes and non-decimating samples leave input ready; a
// decimating sample holds it off while the sequencer walks one tap per cycle
// through the read port of each RAM, then product, scale and round stages.
// Reset clears the delay line through a fill count (no clearing pass),
// the phase count and the registers; coefficients are undefined until written.
// A stalled output holds; the next item is still taken while it waits, and
// the sequencer waits only if a second result is ready before the first left.
// ----------------------------------------------------------------------------
module fir_decimator #(
  parameter int TAPS           = fird_pkg::TAPS_DEFAULT,
  parameter int MAX_DECIMATION = fird_pkg::MAX_DEC_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // sample_in, coef_index, coef_value, zero pad
  input  logic        s_tuser,   // cmd
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // sample_out
  output logic        m_tuser,   // saturated
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = $clog2(TAPS);
  localparam int LEN_W = $clog2(TAPS + 1);
  localparam int DEC_W = $clog2(MAX_DECIMATION + 1);

  // payload unpack
  logic signed [15:0] sample_in;
  logic [5:0]         coef_index;
  logic signed [15:0] coef_value;
  logic               cmd;
  assign sample_in  = s_tdata[15:0];
  assign coef_index = s_tdata[21:16];
  assign coef_value = s_tdata[37:22];
  assign cmd        = s_tuser;

  // ---------------- configuration registers ----------------
  logic [4:0] decimation_factor;
  logic [6:0] filter_length;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_factor <= fird_pkg::DECIMATION_RESET;
      filter_length     <= fird_pkg::FILTER_LENGTH_RESET;
    end else if (cfg_wr) begin
      case (32'(paddr[2]))
        fird_pkg::REG_DECIMATION:    decimation_factor <= pwdata[4:0];
        fird_pkg::REG_FILTER_LENGTH: filter_length     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (32'(paddr[2]))
      fird_pkg::REG_DECIMATION:    prdata = {27'd0, decimation_factor};
      fird_pkg::REG_FILTER_LENGTH: prdata = {25'd0, filter_length};
      default:                     prdata = '0;
    endcase
  end

  // clamp to the supported ranges
  logic [DEC_W-1:0] dec_eff;
  logic [LEN_W-1:0] len_eff;

  always_comb begin
    if (decimation_factor < 5'd2) begin
      dec_eff = DEC_W'(2);
    end else if (32'(decimation_factor) > MAX_DECIMATION) begin
      dec_eff = DEC_W'(MAX_DECIMATION);
    end else begin
      dec_eff = DEC_W'(decimation_factor);
    end
    if (filter_length == 7'd0) begin
      len_eff = LEN_W'(1);
    end else if (32'(filter_length) > TAPS) begin
      len_eff = LEN_W'(TAPS);
    end else begin
      len_eff = LEN_W'(filter_length);
    end
  end

  // ---------------- sequencer ----------------
  fird_pkg::fird_state_t    state, state_next;
  fird_pkg::fird_mac_ctl_t  mac_ctl;

  logic [AW-1:0]    wp;        // next delay RAM slot to write
  logic [AW-1:0]    rd_ptr;    // delay RAM slot of the tap being read
  logic [LEN_W-1:0] k;         // tap counter
  logic [LEN_W-1:0] fill;      // samples in the delay line, saturates at TAPS
  logic [DEC_W-1:0] phase_count;
  logic [DEC_W-1:0] phase_inc;

  logic accept, is_sample, is_coef, emit, tap_last;
  logic mac_valid, mac_take, load_out;
  logic signed [15:0] mac_res;
  logic               mac_sat;

  assign s_tready  = (state == fird_pkg::ST_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign is_sample = accept & (cmd == fird_pkg::CMD_SAMPLE);
  assign is_coef   = accept & (cmd == fird_pkg::CMD_COEF);
  assign phase_inc = phase_count + DEC_W'(1);
  // ">=" so a factor lowered below the running count fires on the next sample
  assign emit      = is_sample & (phase_inc >= dec_eff);
  assign tap_last  = (k == len_eff - LEN_W'(1));
  assign load_out  = mac_valid & (~m_tvalid | m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fird_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mac_ctl.clear = 1'b0;
    mac_ctl.issue = 1'b0;
    mac_ctl.last  = tap_last;
    mac_ctl.zero  = (k >= fill);
    mac_take      = 1'b0;
    case (state)
      fird_pkg::ST_IDLE: begin
        if (emit) begin
          mac_ctl.clear = 1'b1;
          state_next    = fird_pkg::ST_RUN;
        end
      end
      fird_pkg::ST_RUN: begin
        mac_ctl.issue = 1'b1;
        if (tap_last) begin
          state_next = fird_pkg::ST_WAIT;
        end
      end
      fird_pkg::ST_WAIT: begin
        if (load_out) begin
          mac_take   = 1'b1;
          state_next = fird_pkg::ST_IDLE;
        end
      end
      default: state_next = fird_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      fill        <= '0;
      phase_count <= '0;
    end else if (is_sample) begin
      wp          <= wp + AW'(1);
      phase_count <= emit ? '0 : phase_inc;
      if (fill < LEN_W'(TAPS)) begin
        fill <= fill + LEN_W'(1);
      end
    end
  end

  // tap walk: newest sample first, coefficient 0 first
  always_ff @(posedge clk) begin
    if (state == fird_pkg::ST_IDLE) begin
      rd_ptr <= wp;
      k      <= '0;
    end else if (state == fird_pkg::ST_RUN) begin
      rd_ptr <= rd_ptr - AW'(1);
      k      <= k + LEN_W'(1);
    end
  end

  // ---------------- memories ----------------
  logic [15:0] delay_rdata, coef_rdata;
  logic        coef_we;

  assign coef_we = is_coef & (32'(coef_index) < TAPS);

  fird_ram #(.ADDR_W(AW), .DATA_W(16)) u_delay_ram (
    .clk   (clk),
    .we    (is_sample),
    .waddr (wp),
    .wdata (sample_in),
    .raddr (rd_ptr),
    .rdata (delay_rdata)
  );

  fird_ram #(.ADDR_W(AW), .DATA_W(16)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(coef_index)),
    .wdata (coef_value),
    .raddr (k[AW-1:0]),
    .rdata (coef_rdata)
  );

  // ---------------- MAC ----------------
  fird_mac #(.TAPS(TAPS), .MAX_DECIMATION(MAX_DECIMATION)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .sample    (delay_rdata),
    .coef      (coef_rdata),
    .dec       (dec_eff),
    .res_valid (mac_valid),
    .res_take  (mac_take),
    .res       (mac_res),
    .res_sat   (mac_sat)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (mac_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_take) begin
      m_tdata <= mac_res;
      m_tuser <= mac_sat;
    end
  end

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(TAPS))
    else $error("delay fill count beyond tap count");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    32'(phase_count) < MAX_DECIMATION)
    else $error("phase count out of range");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == fird_pkg::ST_IDLE) |-> !mac_valid)
    else $error("MAC result pending while sequencer idle");

  a_run_tap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == fird_pkg::ST_RUN) |-> (k < len_eff))
    else $error("tap counter past filter length");

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    mac_take |=> m_tvalid)
    else $error("result taken but not presented");

endmodule

@@ test/fir_decimator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir_decimator_test: self-checking bench for the streaming FIR decimator
// Drives sample and coefficient items with random gaps and output stalls,
// predicts each decimated result in-bench and checks it against the output
// stream in order. The bench also sweeps the decimation and length registers,
// their out-of-range values included.
// ----------------------------------------------------------------------------
module fir_decimator_test;

  localparam int TAPS      = 64;
  localparam int MAX_DEC   = 16;
  localparam int LIMIT     = 1000000;  // cycles before the run is called hung
  localparam int SETTLE    = 100;      // longer than the slowest MAC pass
  localparam int SEGMENTS  = 12;
  localparam int SEG_ITEMS = 150;

  typedef struct {
    logic               cmd;
    logic signed [15:0] sample_in;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
  } fir_item_t;

  typedef struct {
    logic [15:0] sample_out;
    logic        saturated;
  } fir_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // sample_in[15:0] coef_index[21:16] coef_value[37:22]
  logic        s_tuser = 1'b0; // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // sample_out
  logic        m_tuser;       // saturated
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // stimulus and scoreboard
  fir_item_t   item_queue[$];
  fir_result_t expected_out[$];
  fir_item_t   in_flight;
  int          items_pushed = 0;
  int          items_taken = 0;
  int          errors = 0;
  int          cycles = 0;
  logic        no_gaps = 1'b0;   // both sides run flat out while set

  // predictor state
  logic signed [15:0] delay_taps[TAPS];
  logic signed [15:0] coef_taps[TAPS];
  int                 phase_cnt;
  logic [4:0]         dec_reg;
  logic [6:0]         len_reg;

  fir_decimator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Predict one accepted item: coefficient writes only touch the store,
  // samples shift in and every Nth one produces a filtered result.
  task automatic filter_item(input fir_item_t it);
    int         dec;
    int         len;
    longint     acc;
    longint     rounded;
    fir_result_t res;
    if (it.cmd == fird_pkg::CMD_COEF) begin
      coef_taps[it.coef_index] = it.coef_value;
    end else begin
      for (int n = TAPS - 1; n > 0; n--) delay_taps[n] = delay_taps[n-1];
      delay_taps[0] = it.sample_in;
      // out-of-range register values are clamped
      dec = (dec_reg < 2) ? 2 : (dec_reg > MAX_DEC) ? MAX_DEC : int'(dec_reg);
      phase_cnt++;
      if (phase_cnt >= dec) begin
        phase_cnt = 0;
        len = (len_reg < 1) ? 1 : (len_reg > TAPS) ? TAPS : int'(len_reg);
        acc = 0;
        for (int k = 0; k < len; k++)
          acc += longint'(delay_taps[k]) * longint'(coef_taps[k]);
        acc *= dec;
        rounded = (acc + 64'sd16384) >>> 15;  // Q.15 to integer, half up
        res.saturated = 1'b0;
        if (rounded > 32767) begin
          rounded = 32767;
          res.saturated = 1'b1;
        end else if (rounded < -32768) begin
          rounded = -32768;
          res.saturated = 1'b1;
        end
        res.sample_out = rounded[15:0];
        expected_out.push_back(res);
      end
    end
  endtask

  // driver: predicts at acceptance, then offers the next item or a gap
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        filter_item(in_flight);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (item_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 32)) begin
          in_flight = item_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, in_flight.coef_value, in_flight.coef_index,
                       in_flight.sample_in};
          s_tuser  <= in_flight.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, in-order compare of each result
  always @(posedge clk) begin
    fir_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected result sample_out=%h saturated=%b",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_out.pop_front();
          if (m_tdata !== want.sample_out) begin
            $display("%0t: sample_out expected %h actual %h",
                     $time, want.sample_out, m_tdata);
            errors++;
          end
          if (m_tuser !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b",
                     $time, want.saturated, m_tuser);
            errors++;
          end
        end
      end
      m_tready <= no_gaps || ($urandom_range(0, 99) >= 32);
    end
  end

  // unused fields carry noise; the block must ignore them
  task automatic push_sample(input logic signed [15:0] v);
    fir_item_t it;
    it.cmd        = fird_pkg::CMD_SAMPLE;
    it.sample_in  = v;
    it.coef_index = 6'($urandom);
    it.coef_value = 16'($urandom);
    item_queue.push_back(it);
    items_pushed++;
  endtask

  task automatic push_coef(input logic [5:0] idx, input logic signed [15:0] v);
    fir_item_t it;
    it.cmd        = fird_pkg::CMD_COEF;
    it.sample_in  = 16'($urandom);
    it.coef_index = idx;
    it.coef_value = v;
    item_queue.push_back(it);
    items_pushed++;
  endtask

  // all items taken, all results out, then room for a trailing MAC pass
  task automatic drain();
    while (items_taken < items_pushed || expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == fird_pkg::REG_DECIMATION) dec_reg = val[4:0];
    else if (idx == fird_pkg::REG_FILTER_LENGTH) len_reg = val[6:0];
  endtask

  initial begin
    logic [4:0]         dec_pick;
    logic [6:0]         len_pick;
    int                 amp_shift;
    logic signed [15:0] v;

    for (int k = 0; k < TAPS; k++) begin
      delay_taps[k] = '0;
      coef_taps[k]  = '0;
    end
    phase_cnt = 0;
    dec_reg   = fird_pkg::DECIMATION_RESET;
    len_reg   = fird_pkg::FILTER_LENGTH_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every tap must be written before the first output reads it
    for (int k = 0; k < TAPS; k++) push_coef(6'(k), 16'sh7FFF);

    // full-scale positive then negative input: clips both ways
    repeat (4) push_sample(16'sh7FFF);
    repeat (8) push_sample(16'sh8000);
    // coefficient extremes at both ends of the store
    push_coef(6'd0, 16'sh8000);
    push_coef(6'd63, 16'sh7FFF);
    push_coef(6'd31, 16'sh0000);
    push_sample(16'sh0000);
    push_sample(16'sh0001);
    drain();

    // factor below 2 acts as 2, length 0 acts as 1
    reg_write(fird_pkg::REG_DECIMATION, 32'd1);
    reg_write(fird_pkg::REG_FILTER_LENGTH, 32'd0);
    push_sample(16'shFFFF);
    push_sample(16'sh0001);
    push_sample(16'sd12345);
    push_sample(-16'sd12345);
    drain();

    // factor and length above range clamp; park the phase count at 10
    reg_write(fird_pkg::REG_DECIMATION, 32'd31);
    reg_write(fird_pkg::REG_FILTER_LENGTH, 32'd127);
    repeat (10) push_sample(16'($urandom));
    drain();

    // factor lowered under the phase count: next sample emits at once
    reg_write(fird_pkg::REG_DECIMATION, 32'd3);
    reg_write(fird_pkg::REG_FILTER_LENGTH, 32'd65);
    repeat (3) push_sample(16'($urandom));
    drain();

    // random segments, each with its own register setting and input level
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 9))
        0: dec_pick = 5'd0;
        1: dec_pick = 5'd16;
        2: dec_pick = 5'($urandom_range(17, 31));
        default: dec_pick = 5'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 9))
        0: len_pick = 7'd1;
        1: len_pick = 7'd64;
        2: len_pick = 7'($urandom_range(65, 127));
        default: len_pick = 7'($urandom_range(1, 64));
      endcase
      if (seg == 0) begin
        dec_pick = 5'd2;
        len_pick = 7'd64;
      end
      reg_write(fird_pkg::REG_DECIMATION, {27'd0, dec_pick});
      reg_write(fird_pkg::REG_FILTER_LENGTH, {25'd0, len_pick});
      amp_shift = (seg < 2) ? 0 : $urandom_range(0, 14);
      no_gaps = (seg == 4);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        v = 16'($urandom);
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if ($urandom_range(0, 99) < 15) push_coef(6'($urandom), v);
        else push_sample(v >>> amp_shift);
      end
      drain();
      no_gaps = 1'b0;
    end

    if (errors == 0 && expected_out.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fird_pkg.sv
design/fird_ram.sv
design/fird_mac.sv
design/fir_decimator.sv
test/fir_decimator_test.sv
